// ===== hw/rtl/fjs_pkg.sv =====
// Shared constants and types for the FIFO job server with wait statistics.
// Used by the queue cell, the queue, the statistics stage and the top level.
`default_nettype none
package fjs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int LENGTH_BITS = 8;

   localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W     = 16;
   localparam int TIME_W   = 32;
   localparam int LEN_W    = 8;
   localparam int WAIT_W   = 48;
   localparam int QUEUED_W = 5;
   localparam int SERVED_W = 32;

   localparam logic [LEN_W-1:0] LEN_MASK =
      (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

   // One waiting job as held in a queue cell.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
      logic [LEN_W-1:0]  length;
   } job_type;

   // Queue commands for one tick.
   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   // Per-tick results handed from the server stage to the statistics stage.
   typedef struct packed {
      logic                started;
      logic [ID_W-1:0]     started_id;
      logic [TIME_W-1:0]   started_wait;
      logic                busy_res;
      logic [ID_W-1:0]     serving_id;
      logic [QUEUED_W-1:0] queued;
      logic [SERVED_W-1:0] served_count;
      logic                dropped;
   } stage_type;

endpackage
`default_nettype wire

// ===== hw/rtl/fjs_cell.sv =====
// One cell of the job queue: holds one waiting job and takes either the
// incoming job or its neighbor's job. Depends on fjs_pkg.
`default_nettype none
module fjs_cell (
   input  wire logic            clock,
   input  wire logic            shift,
   input  wire logic            load,
   input  wire fjs_pkg::job_type job_new,
   input  wire fjs_pkg::job_type job_next,
   output fjs_pkg::job_type     job_q
);

   fjs_pkg::job_type job_ff;
   fjs_pkg::job_type job_in;

   always_comb begin
      job_in = job_ff;
      if (load) begin
         job_in = job_new;
      end else if (shift) begin
         job_in = job_next;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_q = job_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/fjs_queue.sv =====
// Job queue built as a row of cells with the head in cell zero; a pop moves
// every job one cell toward the head. Depends on fjs_pkg and fjs_cell.
`default_nettype none
module fjs_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fjs_pkg::qctl_type ctl,
   input  wire fjs_pkg::job_type  job_new,
   output fjs_pkg::job_type      head,
   output logic [fjs_pkg::COUNT_W-1:0] fill,
   output logic [fjs_pkg::COUNT_W-1:0] fill_next
);

   localparam int DEPTH = fjs_pkg::QUEUE_DEPTH;
   localparam int CW    = fjs_pkg::COUNT_W;

   logic [CW-1:0]    fill_ff;
   logic [CW-1:0]    fill_in;
   logic [CW-1:0]    load_at;
   logic             bypass;
   logic             shift;
   logic             wr;
   fjs_pkg::job_type cells_q [DEPTH];

   always_comb begin
      // A job pushed and popped in the same tick on an empty queue never
      // lands in a cell.
      bypass  = ctl.pop && (fill_ff == '0);
      shift   = ctl.pop && !bypass;
      wr      = ctl.push && !bypass;
      load_at = fill_ff - CW'(shift);
      fill_in = fill_ff + CW'(wr) - CW'(shift);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      fjs_pkg::job_type nbr;
      if (i == DEPTH - 1) begin : g_last
         assign nbr = job_new;
      end else begin : g_mid
         assign nbr = cells_q[i+1];
      end
      fjs_cell u_cell (
         .clock    (clock),
         .shift    (shift),
         .load     (wr && (load_at == CW'(i))),
         .job_new  (job_new),
         .job_next (nbr),
         .job_q    (cells_q[i])
      );
   end

   assign head      = cells_q[0];
   assign fill      = fill_ff;
   assign fill_next = fill_in;

endmodule
`default_nettype wire

// ===== hw/rtl/fjs_stats.sv =====
// Second stage: adds the started job's wait to the saturating total and
// registers the result word. Depends on fjs_pkg.
`default_nettype none
module fjs_stats (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               s1_valid,
   input  wire fjs_pkg::stage_type s1,
   output logic                    rsp_valid,
   output logic                    rsp_job_started,
   output logic [15:0]             rsp_started_id,
   output logic [31:0]             rsp_started_wait,
   output logic                    rsp_busy_res,
   output logic [15:0]             rsp_serving_id,
   output logic [4:0]              rsp_queued,
   output logic [31:0]             rsp_served_count,
   output logic [47:0]             rsp_wait_total,
   output logic                    rsp_dropped
);

   localparam int WW = fjs_pkg::WAIT_W;

   logic [WW-1:0]      wait_sum_ff;
   logic [WW-1:0]      wait_sum_in;
   logic [WW:0]        sum_wide;
   logic               valid_ff;
   fjs_pkg::stage_type res_ff;

   always_comb begin
      sum_wide    = {1'b0, wait_sum_ff} + (WW+1)'(s1.started_wait);
      wait_sum_in = wait_sum_ff;
      if (s1_valid && s1.started) begin
         // The total can only pass the top by a carry out of the top bit.
         wait_sum_in = sum_wide[WW] ? fjs_pkg::WAIT_MAX : sum_wide[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_sum_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         wait_sum_ff <= wait_sum_in;
         valid_ff    <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= s1;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_job_started  = res_ff.started;
   assign rsp_started_id   = res_ff.started_id;
   assign rsp_started_wait = res_ff.started_wait;
   assign rsp_busy_res     = res_ff.busy_res;
   assign rsp_serving_id   = res_ff.serving_id;
   assign rsp_queued       = res_ff.queued;
   assign rsp_served_count = res_ff.served_count;
   assign rsp_wait_total   = wait_sum_ff;
   assign rsp_dropped      = res_ff.dropped;

endmodule
`default_nettype wire

// ===== hw/rtl/fifo_job_server_with_wait_stats_top.sv =====
// FIFO job server with wait statistics: one tick per accepted word.
// The result word is registered in the server stage and again in the statistics stage before rsp_valid strobes it.
// Throughput: one word per cycle; busy stays low, the server stage and the
// queue cells update in the accept cycle and the wait total in the cycle after it.
// Reset (synchronous) empties the queue and clears time, ids and counters.
// The receiver cannot stall; each result is on rsp_* for one cycle only.
`default_nettype none
module fifo_job_server_with_wait_stats_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_arrive,
   input  wire logic [7:0]  req_job_length,
   output logic             rsp_valid,
   output logic             rsp_job_started,
   output logic [15:0]      rsp_started_id,
   output logic [31:0]      rsp_started_wait,
   output logic             rsp_busy_res,
   output logic [15:0]      rsp_serving_id,
   output logic [4:0]       rsp_queued,
   output logic [31:0]      rsp_served_count,
   output logic [47:0]      rsp_wait_total,
   output logic             rsp_dropped
);

   localparam int CW = fjs_pkg::COUNT_W;

   logic                          accept;
   logic [fjs_pkg::TIME_W-1:0]    tick_ff, tick_in;
   logic [fjs_pkg::ID_W-1:0]      next_id_ff, next_id_in;
   logic [fjs_pkg::LEN_W-1:0]     remaining_ff, remaining_in;
   logic [fjs_pkg::ID_W-1:0]      active_ff, active_in;
   logic [fjs_pkg::SERVED_W-1:0]  served_ff, served_in;
   logic                          s1_valid_ff;
   fjs_pkg::stage_type            s1_ff, s1_in;

   fjs_pkg::qctl_type             qctl;
   fjs_pkg::job_type              job_new;
   fjs_pkg::job_type              q_head;
   fjs_pkg::job_type              head;
   logic [CW-1:0]                 fill;
   logic [CW-1:0]                 fill_next;
   logic                          full;
   logic                          enq_ok;
   logic                          deq;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      next_id_in       = next_id_ff + fjs_pkg::ID_W'(req_arrive);
      job_new.id       = next_id_ff + fjs_pkg::ID_W'(1);
      job_new.arrival  = tick_ff;
      job_new.length   = req_job_length & fjs_pkg::LEN_MASK;

      full   = (fill >= CW'(fjs_pkg::QUEUE_DEPTH));
      enq_ok = req_arrive && !full;
      // An arrival to an empty queue and an idle server starts at once.
      head   = (fill == '0) ? job_new : q_head;
      deq    = (remaining_ff == '0) && ((fill != '0) || enq_ok);

      qctl.push = accept && enq_ok;
      qctl.pop  = accept && deq;

      tick_in      = tick_ff + fjs_pkg::TIME_W'(1);
      active_in    = active_ff;
      served_in    = served_ff;
      remaining_in = remaining_ff;
      if (deq) begin
         active_in    = head.id;
         served_in    = served_ff + fjs_pkg::SERVED_W'(1);
         remaining_in = (head.length == '0) ? '0 : head.length - fjs_pkg::LEN_W'(1);
      end else if (remaining_ff != '0) begin
         remaining_in = remaining_ff - fjs_pkg::LEN_W'(1);
      end

      s1_in.started      = deq;
      s1_in.started_id   = deq ? head.id : '0;
      s1_in.started_wait = deq ? (tick_ff - head.arrival) : '0;
      s1_in.busy_res     = (remaining_in != '0);
      s1_in.serving_id   = active_in;
      s1_in.queued       = fjs_pkg::QUEUED_W'(fill_next);
      s1_in.served_count = served_in;
      s1_in.dropped      = req_arrive && full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         next_id_ff   <= '0;
         remaining_ff <= '0;
         active_ff    <= '0;
         served_ff    <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            tick_ff      <= tick_in;
            next_id_ff   <= next_id_in;
            remaining_ff <= remaining_in;
            active_ff    <= active_in;
            served_ff    <= served_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   fjs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (qctl),
      .job_new   (job_new),
      .head      (q_head),
      .fill      (fill),
      .fill_next (fill_next)
   );

   fjs_stats u_stats (
      .clock            (clock),
      .reset            (reset),
      .s1_valid         (s1_valid_ff),
      .s1               (s1_ff),
      .rsp_valid        (rsp_valid),
      .rsp_job_started  (rsp_job_started),
      .rsp_started_id   (rsp_started_id),
      .rsp_started_wait (rsp_started_wait),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_serving_id   (rsp_serving_id),
      .rsp_queued       (rsp_queued),
      .rsp_served_count (rsp_served_count),
      .rsp_wait_total   (rsp_wait_total),
      .rsp_dropped      (rsp_dropped)
   );

endmodule
`default_nettype wire
